// File: sv/glds_pkg.sv
`timescale 1ns / 1ps
// Shared constants, result codes and the controller/datapath interface types
// of the grid line-of-sight walker. No dependencies.
package glds_pkg;

  localparam int MAP_DIM       = 64;
  localparam int FRACTION_BITS = 10;
  localparam int CELL_W        = 6;                 // cell index width
  localparam int COORD_W       = 16;                // Q6.10 coordinate
  localparam int LIM_W         = 7;                 // limit registers and walk cell
  localparam int MAP_AW        = 2 * CELL_W;        // map address {x, y}
  localparam int DIST_W        = 17;
  localparam int N_W           = 18;                // boundary offset along an axis
  localparam int LEN_W         = 17;                // floor(sqrt) of squared length
  localparam int MUL_W         = N_W + LEN_W;       // shared multiplier product
  localparam int ROOT_W        = 34;
  localparam int CNT_W         = 5;
  localparam int ITER_LAST     = 16;                // 17 root and quotient digits
  localparam int STEP_BUDGET   = 2 * MAP_DIM + 4;
  localparam int STEP_W        = 8;
  localparam int CLR_W         = MAP_AW;

  localparam logic [DIST_W-1:0] DIST_MAX  = '1;
  localparam logic [ROOT_W-1:0] ROOT_BIT0 = ROOT_W'(1) << 32;
  localparam logic [N_W-1:0]    UNIT      = N_W'(1) << FRACTION_BITS;

  // result codes
  localparam logic [1:0] ST_VISIBLE  = 2'd0;
  localparam logic [1:0] ST_BLOCKED  = 2'd1;
  localparam logic [1:0] ST_SRC_WALL = 2'd2;
  localparam logic [1:0] ST_LEFT_MAP = 2'd3;

  // configuration register indexes
  localparam logic CFG_ROWS    = 1'b0;
  localparam logic CFG_COLUMNS = 1'b1;

  typedef struct packed {
    logic       clr_step;
    logic       load;
    logic       set_res;
    logic       res_zero;
    logic [1:0] res_code;
    logic       mul_sqx;
    logic       mul_sqy;
    logic       sqrt_step;
    logic       mul_a;
    logic       mul_b;
    logic       walk_step;
    logic       mul_dist;
    logic       div_init;
    logic       div_step;
    logic       cnt_clr;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic src_out;
    logic cell_wall;
    logic at_target;
    logic budget_end;
    logic cnt_last;
    logic div_sat;
    logic out_free;
  } stat_t;

endpackage

// File: sv/glds_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the line-of-sight walker: clear pass, set-up, cell walk,
// distance division and result hand-off. Uses glds_pkg.
module glds_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_opcode,
  output logic           in_ready,
  input  glds_pkg::stat_t stat,
  output glds_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SRC   = 4'd2;
  localparam logic [3:0] S_SQY   = 4'd3;
  localparam logic [3:0] S_SQRT  = 4'd4;
  localparam logic [3:0] S_INA   = 4'd5;
  localparam logic [3:0] S_INB   = 4'd6;
  localparam logic [3:0] S_STEP  = 4'd7;
  localparam logic [3:0] S_CHECK = 4'd8;
  localparam logic [3:0] S_DIST  = 4'd9;
  localparam logic [3:0] S_DIVI  = 4'd10;
  localparam logic [3:0] S_DIV   = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_opcode) begin
            state_nxt = S_SRC;
          end
        end
      end
      S_SRC: begin
        cmd.res_zero = 1'b1;
        if (stat.src_out) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = glds_pkg::ST_LEFT_MAP;
          state_nxt    = S_FIN;
        end else if (stat.cell_wall) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = glds_pkg::ST_SRC_WALL;
          state_nxt    = S_FIN;
        end else if (stat.at_target) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = glds_pkg::ST_VISIBLE;
          state_nxt    = S_FIN;
        end else begin
          cmd.mul_sqx = 1'b1;
          state_nxt   = S_SQY;
        end
      end
      S_SQY: begin
        cmd.mul_sqy = 1'b1;
        cmd.cnt_clr = 1'b1;
        state_nxt   = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (stat.cnt_last) begin
          state_nxt = S_INA;
        end
      end
      S_INA: begin
        cmd.mul_a = 1'b1;
        state_nxt = S_INB;
      end
      S_INB: begin
        cmd.mul_b = 1'b1;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd.walk_step = 1'b1;
        state_nxt     = S_CHECK;
      end
      S_CHECK: begin
        // order matters: leaving the map wins over a wall, a wall over the target
        state_nxt = S_DIST;
        if (stat.src_out) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = glds_pkg::ST_LEFT_MAP;
        end else if (stat.cell_wall) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = glds_pkg::ST_BLOCKED;
        end else if (stat.at_target) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = glds_pkg::ST_VISIBLE;
        end else if (stat.budget_end) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = glds_pkg::ST_LEFT_MAP;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_DIST: begin
        cmd.mul_dist = 1'b1;
        state_nxt    = S_DIVI;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        cmd.cnt_clr  = 1'b1;
        state_nxt    = stat.div_sat ? S_FIN : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.cnt_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/glds_dpath.sv
`timescale 1ns / 1ps
// Datapath of the line-of-sight walker: wall map memory, configuration,
// shared multiplier, root and quotient digit units, walk registers, result
// register. Uses glds_pkg.
module glds_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_opcode,
  input  logic [glds_pkg::CELL_W-1:0]       in_cell_x,
  input  logic [glds_pkg::CELL_W-1:0]       in_cell_y,
  input  logic                              in_wall_bit,
  input  logic [glds_pkg::COORD_W-1:0]      in_source_x,
  input  logic [glds_pkg::COORD_W-1:0]      in_source_y,
  input  logic [glds_pkg::COORD_W-1:0]      in_target_x,
  input  logic [glds_pkg::COORD_W-1:0]      in_target_y,
  input  logic                              cfg_valid,
  input  logic                              cfg_index,
  input  logic [glds_pkg::LIM_W-1:0]        cfg_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic                              out_last_cross_vertical,
  output logic [glds_pkg::DIST_W-1:0]       out_ray_distance,
  input  glds_pkg::cmd_t                    cmd,
  output glds_pkg::stat_t                   stat
);

  localparam int CW = glds_pkg::CELL_W;
  localparam int LW = glds_pkg::LIM_W;
  localparam int FB = glds_pkg::FRACTION_BITS;
  localparam int XW = glds_pkg::COORD_W;
  localparam int NW = glds_pkg::N_W;
  localparam int MW = glds_pkg::MUL_W;
  localparam int RW = glds_pkg::ROOT_W;
  localparam int DW = glds_pkg::DIST_W;
  localparam int MAP_WORDS = glds_pkg::MAP_DIM * glds_pkg::MAP_DIM;

  logic map_mem [0:MAP_WORDS-1];

  logic [LW-1:0]             rows_r, cols_r;
  logic [glds_pkg::CLR_W-1:0] clr_addr_r;
  logic [CW-1:0]             tcx_r, tcy_r;
  logic [LW-1:0]             cur_x_r, cur_y_r;
  logic                      negx_r, negy_r;
  logic [XW-1:0]             adx_r, ady_r;
  logic [NW-1:0]             nx_r, ny_r, last_n_r;
  logic [MW-1:0]             acc_a_r, acc_b_r, prod_r;
  logic [RW-1:0]             v_r, root_r, bit_r;
  logic [XW-1:0]             rem_r;
  logic [DW-1:0]             q_r;
  logic                      vert_r;
  logic [1:0]                code_r;
  logic [glds_pkg::CNT_W-1:0] cnt_r;
  logic [glds_pkg::STEP_W-1:0] steps_r;
  logic                      wall_r;
  logic                      out_valid_r;
  logic [1:0]                out_status_r;
  logic                      out_vert_r;
  logic [DW-1:0]             out_dist_r;

  logic [LW-1:0]             xlim, ylim, next_cx, next_cy;
  logic                      take_x;
  logic [glds_pkg::MAP_AW-1:0] rd_addr;
  logic [CW-1:0]             src_cx, src_cy;
  logic [NW-1:0]             mul_a;
  logic [glds_pkg::LEN_W-1:0] mul_b;
  logic [MW-1:0]             mul_p;
  logic [RW-1:0]             trial;
  logic [XW-1:0]             div_d;
  logic [XW:0]               rem2;
  logic                      rem_ge;

  assign xlim = (rows_r > LW'(glds_pkg::MAP_DIM)) ? LW'(glds_pkg::MAP_DIM) : rows_r;
  assign ylim = (cols_r > LW'(glds_pkg::MAP_DIM)) ? LW'(glds_pkg::MAP_DIM) : cols_r;

  assign src_cx = in_source_x[XW-1:FB];
  assign src_cy = in_source_y[XW-1:FB];

  // ties step in y
  assign take_x  = acc_a_r < acc_b_r;
  assign next_cx = negx_r ? cur_x_r - LW'(1) : cur_x_r + LW'(1);
  assign next_cy = negy_r ? cur_y_r - LW'(1) : cur_y_r + LW'(1);

  always_comb begin
    if (cmd.load) begin
      rd_addr = {src_cx, src_cy};
    end else if (take_x) begin
      rd_addr = {next_cx[CW-1:0], cur_y_r[CW-1:0]};
    end else begin
      rd_addr = {cur_x_r[CW-1:0], next_cy[CW-1:0]};
    end
  end

  // map: clear sweep, cell writes, one registered read a cycle
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      map_mem[clr_addr_r] <= 1'b0;
    end else if (cmd.load && !in_opcode) begin
      map_mem[{in_cell_x, in_cell_y}] <= in_wall_bit;
    end
    wall_r <= map_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r     <= LW'(glds_pkg::MAP_DIM);
      cols_r     <= LW'(glds_pkg::MAP_DIM);
      clr_addr_r <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == glds_pkg::CFG_ROWS) begin
          rows_r <= cfg_data;
        end else begin
          cols_r <= cfg_data;
        end
      end
      if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.mul_sqx) begin
      mul_a = NW'(adx_r);
      mul_b = glds_pkg::LEN_W'(adx_r);
    end else if (cmd.mul_sqy) begin
      mul_a = NW'(ady_r);
      mul_b = glds_pkg::LEN_W'(ady_r);
    end else if (cmd.mul_a) begin
      mul_a = nx_r;
      mul_b = glds_pkg::LEN_W'(ady_r);
    end else if (cmd.mul_b) begin
      mul_a = ny_r;
      mul_b = glds_pkg::LEN_W'(adx_r);
    end else if (cmd.mul_dist) begin
      mul_a = last_n_r;
      mul_b = root_r[glds_pkg::LEN_W-1:0];
    end
  end

  assign mul_p = MW'(mul_a) * MW'(mul_b);
  assign trial = root_r + bit_r;

  assign div_d  = vert_r ? adx_r : ady_r;
  assign rem2   = {rem_r, q_r[DW-1]};
  assign rem_ge = rem2 >= {1'b0, div_d};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tcx_r   <= in_target_x[XW-1:FB];
      tcy_r   <= in_target_y[XW-1:FB];
      cur_x_r <= LW'(src_cx);
      cur_y_r <= LW'(src_cy);
      negx_r  <= in_target_x < in_source_x;
      negy_r  <= in_target_y < in_source_y;
      adx_r   <= (in_target_x >= in_source_x) ? in_target_x - in_source_x
                                              : in_source_x - in_target_x;
      ady_r   <= (in_target_y >= in_source_y) ? in_target_y - in_source_y
                                              : in_source_y - in_target_y;
      nx_r    <= (in_target_x < in_source_x) ? NW'(in_source_x[FB-1:0])
                                             : glds_pkg::UNIT - NW'(in_source_x[FB-1:0]);
      ny_r    <= (in_target_y < in_source_y) ? NW'(in_source_y[FB-1:0])
                                             : glds_pkg::UNIT - NW'(in_source_y[FB-1:0]);
    end
    if (cmd.mul_sqx) begin
      v_r <= mul_p[RW-1:0];
    end
    if (cmd.mul_sqy) begin
      v_r    <= v_r + mul_p[RW-1:0];
      root_r <= '0;
      bit_r  <= glds_pkg::ROOT_BIT0;
    end
    if (cmd.sqrt_step) begin
      if (v_r >= trial) begin
        v_r    <= v_r - trial;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.mul_a) begin
      acc_a_r <= mul_p;
    end
    if (cmd.mul_b) begin
      acc_b_r <= mul_p;
      steps_r <= '0;
    end
    if (cmd.walk_step) begin
      steps_r <= steps_r + 1'b1;
      if (take_x) begin
        vert_r   <= 1'b1;
        last_n_r <= nx_r;
        nx_r     <= nx_r + glds_pkg::UNIT;
        acc_a_r  <= acc_a_r + (MW'(ady_r) << FB);
        cur_x_r  <= next_cx;
      end else begin
        vert_r   <= 1'b0;
        last_n_r <= ny_r;
        ny_r     <= ny_r + glds_pkg::UNIT;
        acc_b_r  <= acc_b_r + (MW'(adx_r) << FB);
        cur_y_r  <= next_cy;
      end
    end
    if (cmd.set_res) begin
      code_r <= cmd.res_code;
      if (cmd.res_zero) begin
        vert_r <= 1'b0;
        q_r    <= '0;
      end
    end
    if (cmd.mul_dist) begin
      prod_r <= mul_p;
    end
    if (cmd.div_init) begin
      if (stat.div_sat) begin
        q_r <= glds_pkg::DIST_MAX;
      end else begin
        rem_r <= prod_r[DW+XW-1:DW];
        q_r   <= prod_r[DW-1:0];
      end
    end
    if (cmd.div_step) begin
      rem_r <= rem_ge ? XW'(rem2 - {1'b0, div_d}) : rem2[XW-1:0];
      q_r   <= {q_r[DW-2:0], rem_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.sqrt_step || cmd.div_step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= code_r;
      out_vert_r   <= vert_r;
      out_dist_r   <= q_r;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_status              = out_status_r;
  assign out_last_cross_vertical = out_vert_r;
  assign out_ray_distance        = out_dist_r;

  assign stat.clr_last   = &clr_addr_r;
  assign stat.src_out    = (cur_x_r >= xlim) || (cur_y_r >= ylim);
  assign stat.cell_wall  = wall_r;
  assign stat.at_target  = (cur_x_r == LW'(tcx_r)) && (cur_y_r == LW'(tcy_r));
  assign stat.budget_end = steps_r == glds_pkg::STEP_W'(glds_pkg::STEP_BUDGET);
  assign stat.cnt_last   = cnt_r == glds_pkg::CNT_W'(glds_pkg::ITER_LAST);
  assign stat.div_sat    = prod_r[MW-1:DW] >= NW'(div_d);
  assign stat.out_free   = !out_valid_r || out_ready;

endmodule

// File: sv/grid_line_of_sight_dda_core.sv
`timescale 1ns / 1ps
// Top level of the grid line-of-sight walker: sequencer plus datapath.
// Depends on glds_pkg, glds_ctrl and glds_dpath.
//
//   channel | ports                                   | beat carries
//   in      | in_valid / in_ready                     | map write or ray cast
//   out     | out_valid / out_ready                   | status, axis, distance
//   cfg     | cfg_valid / cfg_ready, cfg_index        | map limits (rows, columns)
//
// A cast that stops at the source cell goes straight to the result; a full walk's
// run time is set by the 17-digit root, the step/map-read loop and the 17-digit divide.
// After reset a clearing pass zeroes the map, one cell a cycle; no beat is
// taken on in meanwhile. A finished result waits in its register while the
// next beat is taken; a cast only ends once that register is free.
module grid_line_of_sight_dda_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_opcode,
  input  logic [glds_pkg::CELL_W-1:0]       in_cell_x,
  input  logic [glds_pkg::CELL_W-1:0]       in_cell_y,
  input  logic                              in_wall_bit,
  input  logic [glds_pkg::COORD_W-1:0]      in_source_x,
  input  logic [glds_pkg::COORD_W-1:0]      in_source_y,
  input  logic [glds_pkg::COORD_W-1:0]      in_target_x,
  input  logic [glds_pkg::COORD_W-1:0]      in_target_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic                              out_last_cross_vertical,
  output logic [glds_pkg::DIST_W-1:0]       out_ray_distance,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [glds_pkg::LIM_W-1:0]        cfg_data
);

  glds_pkg::cmd_t  cmd;
  glds_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  glds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  glds_dpath u_dpath (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_opcode               (in_opcode),
    .in_cell_x               (in_cell_x),
    .in_cell_y               (in_cell_y),
    .in_wall_bit             (in_wall_bit),
    .in_source_x             (in_source_x),
    .in_source_y             (in_source_y),
    .in_target_x             (in_target_x),
    .in_target_y             (in_target_y),
    .cfg_valid               (cfg_valid),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .out_ready               (out_ready),
    .out_valid               (out_valid),
    .out_status              (out_status),
    .out_last_cross_vertical (out_last_cross_vertical),
    .out_ray_distance        (out_ray_distance),
    .cmd                     (cmd),
    .stat                    (stat)
  );

endmodule

// File: sv/glds_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the line-of-sight walker, bound to the top level.
// Depends on glds_pkg and grid_line_of_sight_dda_core.
module glds_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_opcode,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  out_status,
  input logic                        out_last_cross_vertical,
  input logic [glds_pkg::DIST_W-1:0] out_ray_distance
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_ray_distance) && $stable(out_last_cross_vertical))
    else $error("stalled result beat changed");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat shown after reset");

  a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode |=> !in_ready)
    else $error("new beat taken during a cast");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_opcode |=> in_ready)
    else $error("map write did not return to idle");

  a_src_wall_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == glds_pkg::ST_SRC_WALL)
      |-> (out_ray_distance == '0) && !out_last_cross_vertical)
    else $error("source-in-wall result carries a crossing");

endmodule

bind grid_line_of_sight_dda_core glds_checker u_glds_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .in_valid                (in_valid),
  .in_ready                (in_ready),
  .in_opcode               (in_opcode),
  .out_valid               (out_valid),
  .out_ready               (out_ready),
  .out_status              (out_status),
  .out_last_cross_vertical (out_last_cross_vertical),
  .out_ray_distance        (out_ray_distance)
);

// File: verif/grid_line_of_sight_dda_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for grid_line_of_sight_dda_core: map writes and ray casts
// against an in-bench line-of-sight predictor. Depends on glds_pkg and the core.
module grid_line_of_sight_dda_core_tb;
  import glds_pkg::*;

  typedef struct {
    logic [1:0]        status;
    logic              vert;
    logic [DIST_W-1:0] span;
  } sight_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_opcode = 1'b0, in_wall_bit = 1'b0;
  logic [CELL_W-1:0] in_cell_x = '0, in_cell_y = '0;
  logic [COORD_W-1:0] in_source_x = '0, in_source_y = '0, in_target_x = '0, in_target_y = '0;
  logic in_ready, out_valid, out_last_cross_vertical;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [DIST_W-1:0] out_ray_distance;
  logic cfg_valid = 1'b0, cfg_ready, cfg_index = CFG_ROWS;
  logic [LIM_W-1:0] cfg_data = '0;

  grid_line_of_sight_dda_core uut (.*);

  // predictor state
  bit          walls [MAP_DIM*MAP_DIM];
  int unsigned x_limit = 64, y_limit = 64;
  sight_t      sight_queue[$];
  int          mismatches = 0, casts_sent = 0, writes_sent = 0, results_seen = 0;
  int          send_idle_pct = 0, stall_pct = 0;
  longint      cycles = 0;
  localparam longint CYCLE_LIMIT = 3_000_000;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL grid_line_of_sight_dda_core");
      $finish;
    end
  end

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [DIST_W-1:0] along_ray(longint unsigned n, longint unsigned len,
                                                  longint unsigned d);
    longint unsigned q;
    if (d == 0) return DIST_MAX;
    q = (n * len) / d;
    return (q > DIST_MAX) ? DIST_MAX : q[DIST_W-1:0];
  endfunction

  function automatic bit wall_at(int cx, int cy);
    return walls[cx*MAP_DIM + cy];
  endfunction

  function automatic sight_t trace_sight(logic [COORD_W-1:0] sx, sy, tx, ty);
    sight_t r;
    int cx, cy, tcx, tcy, stx, sty;
    longint unsigned adx, ady, len, nx, ny;
    r.status = ST_VISIBLE; r.vert = 0; r.span = '0;
    cx = sx >> FRACTION_BITS; cy = sy >> FRACTION_BITS;
    tcx = tx >> FRACTION_BITS; tcy = ty >> FRACTION_BITS;
    if (cx >= x_limit || cy >= y_limit) begin
      r.status = ST_LEFT_MAP; return r;
    end
    if (wall_at(cx, cy)) begin
      r.status = ST_SRC_WALL; return r;
    end
    if (cx == tcx && cy == tcy) return r;
    adx = (tx >= sx) ? tx - sx : sx - tx;
    ady = (ty >= sy) ? ty - sy : sy - ty;
    len = root_floor(adx*adx + ady*ady);
    if (tx < sx) begin
      stx = -1; nx = sx - (cx << FRACTION_BITS);
    end else begin
      stx = 1; nx = ((cx + 1) << FRACTION_BITS) - sx;
    end
    if (ty < sy) begin
      sty = -1; ny = sy - (cy << FRACTION_BITS);
    end else begin
      sty = 1; ny = ((cy + 1) << FRACTION_BITS) - sy;
    end
    for (int i = 0; i < STEP_BUDGET; i++) begin
      if (nx * ady < ny * adx) begin
        r.vert = 1; r.span = along_ray(nx, len, adx); nx += UNIT; cx += stx;
      end else begin
        r.vert = 0; r.span = along_ray(ny, len, ady); ny += UNIT; cy += sty;
      end
      if (cx < 0 || cy < 0 || cx >= x_limit || cy >= y_limit) begin
        r.status = ST_LEFT_MAP; return r;
      end
      if (wall_at(cx, cy)) begin
        r.status = ST_BLOCKED; return r;
      end
      if (cx == tcx && cy == tcy) return r;
    end
    r.status = ST_LEFT_MAP;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
  endtask

  // result side: random stall, check every accepted beat
  always @(posedge clk) begin
    sight_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (sight_queue.size() == 0) begin
        report_mismatch("unexpected result status", out_status, -1);
      end else begin
        want = sight_queue.pop_front();
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_last_cross_vertical !== want.vert)
          report_mismatch("last_cross_vertical", out_last_cross_vertical, want.vert);
        if (out_ray_distance !== want.span)
          report_mismatch("ray_distance", out_ray_distance, want.span);
      end
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // valid drops only when the sender idles or drains
  task automatic send_beat(bit op, logic [CELL_W-1:0] wx, wy, bit wb,
                           logic [COORD_W-1:0] sx, sy, tx, ty);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; in_opcode <= op; in_cell_x <= wx; in_cell_y <= wy;
    in_wall_bit <= wb; in_source_x <= sx; in_source_y <= sy;
    in_target_x <= tx; in_target_y <= ty;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op) begin
      sight_queue.push_back(trace_sight(sx, sy, tx, ty));
      casts_sent++;
    end else begin
      walls[wx*MAP_DIM + wy] = wb;
      writes_sent++;
    end
  endtask

  task automatic write_cell(int x, int y, bit wb);
    send_beat(1'b0, CELL_W'(x), CELL_W'(y), wb, COORD_W'($urandom), COORD_W'($urandom),
              COORD_W'($urandom), COORD_W'($urandom));
  endtask

  task automatic cast_ray(logic [COORD_W-1:0] sx, sy, tx, ty);
    send_beat(1'b1, CELL_W'($urandom), CELL_W'($urandom), 1'($urandom), sx, sy, tx, ty);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sight_queue.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic set_limit(bit idx, int v);
    drain_results();
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= LIM_W'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_ROWS) x_limit = (v < MAP_DIM) ? v : MAP_DIM;
    else y_limit = (v < MAP_DIM) ? v : MAP_DIM;
  endtask

  // coordinate mostly inside the first lim cells, sometimes anywhere
  function automatic logic [COORD_W-1:0] pick_coord(int lim);
    if ($urandom_range(9) == 0) return COORD_W'($urandom);
    return COORD_W'($urandom_range(lim * 1024 - 1));
  endfunction

  task automatic test_directed();
    write_cell(5, 5, 1'b1);
    write_cell(63, 63, 1'b1);
    write_cell(20, 10, 1'b1);
    cast_ray(16'h1400, 16'h1400, 16'h8000, 16'h8000); // source in wall
    cast_ray(16'h0200, 16'h0200, 16'h03FF, 16'h0001); // same cell
    cast_ray(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF); // to far corner wall
    cast_ray(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    cast_ray(16'h0400, 16'h2A00, 16'h7000, 16'h2A00); // horizontal into wall
    cast_ray(16'h0800, 16'h0800, 16'h0800, 16'h4000); // pure y
    cast_ray(16'h0800, 16'h0800, 16'h0000, 16'h0000); // exact corner tie
    cast_ray(16'h8000, 16'h8000, 16'h0000, 16'h0000);
    write_cell(5, 5, 1'b0);
    cast_ray(16'h1400, 16'h1400, 16'h1000, 16'h1000);
    send_idle_pct = 0;
    drain_results();                                 // sender holds until all results back
    set_limit(CFG_ROWS, 10);
    set_limit(CFG_COLUMNS, 1);
    cast_ray(16'h0000, 16'h0000, 16'h7000, 16'h0100); // target off map
    cast_ray(16'h3000, 16'h0000, 16'h0000, 16'h0000); // source off map
    set_limit(CFG_ROWS, 127);
    set_limit(CFG_COLUMNS, 64);
    cast_ray(16'hFFFF, 16'h0400, 16'h0000, 16'h0400);
  endtask

  task automatic test_random(int n, int lim_x, int lim_y);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0)
        write_cell($urandom_range(lim_x), $urandom_range(lim_y), $urandom_range(9) < 3);
      else if ($urandom_range(15) == 0)
        cast_ray(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                 COORD_W'($urandom));
      else
        cast_ray(pick_coord(lim_x), pick_coord(lim_y), pick_coord(lim_x), pick_coord(lim_y));
    end
  endtask

  task automatic test_limits();
    set_limit(CFG_ROWS, 1);
    set_limit(CFG_COLUMNS, 64);
    test_random(30, 2, 64);
    set_limit(CFG_ROWS, 20);
    set_limit(CFG_COLUMNS, 12);
    test_random(60, 22, 14);
    set_limit(CFG_ROWS, 64);
    set_limit(CFG_COLUMNS, 64);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    send_idle_pct = 0;  stall_pct = 0;  test_random(200, 63, 63);
    send_idle_pct = 88; stall_pct = 0;  test_random(80, 63, 63);
    send_idle_pct = 0;  stall_pct = 88; test_random(80, 63, 63);
    send_idle_pct = 24; stall_pct = 24; test_random(120, 63, 63);
    send_idle_pct = 0;  stall_pct = 0;  test_limits();
    drain_results();
    $display("covered %0d casts and %0d map writes, %0d results checked",
             casts_sent, writes_sent, results_seen);
    $display("map limits varied between 1 and 127 under four idle/stall mixes");
    if (mismatches == 0)
      $display("PASS grid_line_of_sight_dda_core");
    else
      $display("FAIL grid_line_of_sight_dda_core");
    $finish;
  end
endmodule
